>>> design/amom_pkg.sv
// Shared types and constants of the alpha-mask overlay marker.
// Depends on nothing; imported by the result queue and the marker unit.
`timescale 1ns / 1ps
`default_nettype none

package amom_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned PIX_W         = 8;
    localparam int unsigned ROW_W         = 12;
    localparam int unsigned FW_W          = 11;
    localparam int unsigned FH_W          = 13;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 13;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam logic [PIX_W-1:0] ALPHA_LIMIT      = 8'd128;
    localparam logic [FH_W-1:0]  MAX_HEIGHT       = 13'd4096;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
    localparam logic [PIX_W-1:0] MARK_VALUE_RST   = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_MARK_VALUE   = 2'd2
    } cfg_reg_t;

    // Up to three results released by one input: above, left, current.
    typedef struct packed {
        logic             has_above;
        logic             has_left;
        logic             has_cur;
        logic [PIX_W-1:0] pix_above;
        logic [PIX_W-1:0] pix_left;
        logic [PIX_W-1:0] pix_cur;
        logic [ROW_W-1:0] row;
    } bundle_t;

endpackage

`default_nettype wire

>>> design/amom_line_ram.sv
// One-row line buffer: one write port, one read port, registered read data.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module amom_line_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/amom_result_queue.sv
// Result queue: holds per-input result bundles and hands them out one
// transfer at a time. Depends on amom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amom_result_queue #(
    parameter int unsigned COL_W = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire amom_pkg::bundle_t             push_bundle,
    input  wire logic [COL_W-1:0]              push_col,
    input  wire logic                          reserve,
    output logic                               item_room,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [amom_pkg::PIX_W-1:0]         pixel_out,
    output logic [COL_W-1:0]                   col,
    output logic [amom_pkg::ROW_W-1:0]         row,
    output logic                               run_last
);

    import amom_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    bundle_t          bundle_q [QUEUE_DEPTH];
    logic [COL_W-1:0] col_q    [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       done_reg;   // [0] above sent, [1] left sent
    logic [1:0]       done_next;

    bundle_t          head;
    logic [COL_W-1:0] head_col;
    logic             sel_above;
    logic             sel_left;
    logic             sel_cur;
    logic             xfer;
    logic             pop;

    always_comb
    begin
        head      = bundle_q[rd_ptr_reg];
        head_col  = col_q[rd_ptr_reg];
        sel_above = head.has_above && !done_reg[0];
        sel_left  = !sel_above && head.has_left && !done_reg[1];
        sel_cur   = !sel_above && !sel_left;
        run_last  = sel_cur || (sel_left && !head.has_cur)
                    || (sel_above && !head.has_left && !head.has_cur);
        if (sel_above)
        begin
            pixel_out = head.pix_above;
        end
        else if (sel_left)
        begin
            pixel_out = head.pix_left;
        end
        else
        begin
            pixel_out = head.pix_cur;
        end
        col = sel_left ? head_col - COL_W'(1) : head_col;
        row = sel_above ? head.row - ROW_W'(1) : head.row;
    end

    assign out_valid = (count_reg != '0);
    assign xfer      = out_valid && !out_stall;
    assign pop       = xfer && run_last;

    // Room for the bundle in flight and the one about to enter.
    assign item_room = (CNT_W + 1)'(count_reg) + (CNT_W + 1)'(reserve)
                       < (CNT_W + 1)'(QUEUE_DEPTH);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        done_next = done_reg;
        if (pop)
        begin
            done_next = '0;
        end
        else if (xfer)
        begin
            done_next = done_reg | {sel_left, sel_above};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            done_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bundle_q[wr_ptr_reg] <= push_bundle;
            col_q[wr_ptr_reg]    <= push_col;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_done_clear_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (done_reg == '0))
        else $error("stale progress on empty queue");

    a_bundle_held: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && !run_last) |=> out_valid)
        else $error("bundle dropped before its last result");

endmodule

`default_nettype wire

>>> design/alpha_mask_overlay_marker_unit.sv
// Path: a result passes through the stage 1 registers and the result queue; the queue
//   adds time only while it holds earlier results or the output is stalled.
// Throughput: one input per cycle in every row but the last, while the queue has room;
//   in the last row an input releases up to three results and the output port sets the rate.
// Reset: control, counters and left-neighbour state clear at once; line buffers
//   are not cleared and there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module alpha_mask_overlay_marker_unit #(
    parameter int unsigned MAX_WIDTH = amom_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [amom_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [amom_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [amom_pkg::PIX_W-1:0]         pixel_in,
    input  wire logic [amom_pkg::PIX_W-1:0]         alpha_in,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [amom_pkg::PIX_W-1:0]              pixel_out,
    output logic [$clog2(MAX_WIDTH)-1:0]            col,
    output logic [amom_pkg::ROW_W-1:0]              row,
    output logic                                    run_last
);

    import amom_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    // ---------------------------------------------------------------
    // Configuration registers: every write transfer is taken at once.
    // ---------------------------------------------------------------
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [PIX_W-1:0] mark_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            mark_value_reg   <= MARK_VALUE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                REG_MARK_VALUE:   mark_value_reg   <= cfg_data[PIX_W-1:0];
                default:          ;   // unmapped index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: raster position, frame edges, line-buffer read issue.
    // ---------------------------------------------------------------
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic             last_col0;
    logic             last_row0;
    logic [1:0]       phase0;
    logic             has_above0;
    logic             has_left0;
    logic             has_cur0;
    logic             in_accept;
    logic             q_room;

    // Clamp the programmed size to the supported range; zero acts as one.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_m1 = '0;
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_m1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = COL_W'(32'(frame_width_reg) - 32'd1);
        end

        if (frame_height_reg == '0)
        begin
            h_m1 = '0;
        end
        else if (frame_height_reg > MAX_HEIGHT)
        begin
            h_m1 = ROW_W'(MAX_HEIGHT - FH_W'(1));
        end
        else
        begin
            h_m1 = ROW_W'(frame_height_reg - FH_W'(1));
        end
    end

    assign last_col0  = (col_count_reg >= w_m1);
    assign last_row0  = (row_count_reg >= h_m1);
    assign phase0     = 2'({1'b0, col_count_reg}) + row_count_reg[1:0];
    assign has_above0 = (row_count_reg != '0);
    assign has_left0  = (col_count_reg != '0) && last_row0;
    assign has_cur0   = last_col0 && last_row0;

    assign in_stall  = !q_room;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_accept)
        begin
            if (last_col0)
            begin
                col_count_reg <= '0;
                row_count_reg <= last_row0 ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 registers: the item whose line-buffer data is now back.
    // ---------------------------------------------------------------
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_x_reg;
    logic [ROW_W-1:0] s1_y_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [PIX_W-1:0] s1_alpha_reg;
    logic             s1_phase0_reg;
    logic             s1_last_col_reg;
    logic             s1_has_above_reg;
    logic             s1_has_left_reg;
    logic             s1_has_cur_reg;

    // Forwarding of writes that land in the same cycle as the read.
    logic             a_hit_reg;
    logic [PIX_W-1:0] a_fwd_reg;
    logic             pm_hit_reg;
    logic [PIX_W:0]   pm_fwd_reg;
    logic             a_hit_next;
    logic             pm_hit_next;
    logic [PIX_W:0]   pm_fwd_next;

    // Left neighbour and the deferred last-column write.
    logic [PIX_W-1:0] left_alpha_reg;
    logic [PIX_W-1:0] left_pixel_reg;
    logic             left_mark_reg;
    logic             pend_valid_reg;
    logic [COL_W-1:0] pend_addr_reg;
    logic [PIX_W:0]   pend_data_reg;

    // Line buffers: alpha in one memory, pixel and mark together in another.
    logic [PIX_W-1:0] alpha_q;
    logic [PIX_W:0]   pm_q;
    logic             pm_we;
    logic [COL_W-1:0] pm_waddr;
    logic [PIX_W:0]   pm_wdata;
    logic             left_we;

    // Stage 1 datapath
    logic [PIX_W-1:0] ia;
    logic [PIX_W-1:0] ap;
    logic             am_raw;
    logic             rule1;
    logic             rule2;
    logic             rule3;
    logic             lt_left;
    logic             lt_above;
    logic             cm;
    logic             left_mark_eff;
    logic             am;
    logic             s1_push;
    bundle_t          s1_bundle;

    assign ia              = a_hit_reg ? a_fwd_reg : alpha_q;
    assign {ap, am_raw}    = pm_hit_reg ? pm_fwd_reg : pm_q;

    assign lt_left  = (s1_alpha_reg < left_alpha_reg);
    assign lt_above = (s1_alpha_reg < ia);
    assign rule1    = (s1_alpha_reg < ALPHA_LIMIT) && s1_phase0_reg;
    assign rule2    = !rule1 && (s1_x_reg != '0) && (s1_alpha_reg != left_alpha_reg);
    assign rule3    = !rule1 && !rule2 && (s1_y_reg != '0) && (s1_alpha_reg != ia);

    // The lower alpha of a differing pair gets the mark.
    assign cm            = rule1 || (rule2 && lt_left) || (rule3 && lt_above);
    assign left_mark_eff = left_mark_reg || (rule2 && !lt_left);
    assign am            = am_raw || (rule3 && !lt_above);

    always_comb
    begin
        s1_bundle.has_above = s1_has_above_reg;
        s1_bundle.has_left  = s1_has_left_reg;
        s1_bundle.has_cur   = s1_has_cur_reg;
        s1_bundle.pix_above = am ? mark_value_reg : ap;
        s1_bundle.pix_left  = left_mark_eff ? mark_value_reg : left_pixel_reg;
        s1_bundle.pix_cur   = cm ? mark_value_reg : s1_pixel_reg;
        s1_bundle.row       = s1_y_reg;
    end

    assign s1_push = s1_valid_reg
                     && (s1_has_above_reg || s1_has_left_reg || s1_has_cur_reg);

    // The left neighbour is final once its right-hand pixel is seen: write it
    // back. The last column has no right-hand pixel, so its write is held in the
    // pend registers; the next item is always column 0, which leaves the port free.
    assign left_we  = s1_valid_reg && (s1_x_reg != '0);
    assign pm_we    = left_we || pend_valid_reg;
    assign pm_waddr = left_we ? s1_x_reg - COL_W'(1) : pend_addr_reg;
    assign pm_wdata = left_we ? {left_pixel_reg, left_mark_eff} : pend_data_reg;

    // Forward whatever lands on the read address this cycle, the held
    // last-column write of the item in stage 1 taking priority.
    always_comb
    begin
        a_hit_next  = s1_valid_reg && (s1_x_reg == col_count_reg);
        pm_hit_next = 1'b0;
        pm_fwd_next = pm_wdata;
        if (s1_valid_reg && s1_last_col_reg && (s1_x_reg == col_count_reg))
        begin
            pm_hit_next = 1'b1;
            pm_fwd_next = {s1_pixel_reg, cm};
        end
        else if (pm_we && (pm_waddr == col_count_reg))
        begin
            pm_hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            left_alpha_reg <= '0;
            left_pixel_reg <= '0;
            left_mark_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= in_accept;
            pend_valid_reg <= s1_valid_reg && s1_last_col_reg;
            if (s1_valid_reg)
            begin
                left_alpha_reg <= s1_alpha_reg;
                left_pixel_reg <= s1_pixel_reg;
                left_mark_reg  <= cm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg         <= col_count_reg;
            s1_y_reg         <= row_count_reg;
            s1_pixel_reg     <= pixel_in;
            s1_alpha_reg     <= alpha_in;
            s1_phase0_reg    <= (phase0 == 2'd0);
            s1_last_col_reg  <= last_col0;
            s1_has_above_reg <= has_above0;
            s1_has_left_reg  <= has_left0;
            s1_has_cur_reg   <= has_cur0;
            a_hit_reg        <= a_hit_next;
            a_fwd_reg        <= s1_alpha_reg;
            pm_hit_reg       <= pm_hit_next;
            pm_fwd_reg       <= pm_fwd_next;
        end
        if (s1_valid_reg && s1_last_col_reg)
        begin
            pend_addr_reg <= s1_x_reg;
            pend_data_reg <= {s1_pixel_reg, cm};
        end
    end

    amom_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIX_W)
    ) u_alpha_line (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_x_reg),
        .wr_data (s1_alpha_reg),
        .rd_en   (in_accept),
        .rd_addr (col_count_reg),
        .rd_data (alpha_q)
    );

    amom_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIX_W + 1)
    ) u_pm_line (
        .clk     (clk),
        .wr_en   (pm_we),
        .wr_addr (pm_waddr),
        .wr_data (pm_wdata),
        .rd_en   (in_accept),
        .rd_addr (col_count_reg),
        .rd_data (pm_q)
    );

    // ---------------------------------------------------------------
    // Result queue: decouples the output stall from the pipeline.
    // ---------------------------------------------------------------
    amom_result_queue #(
        .COL_W (COL_W)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (s1_push),
        .push_bundle (s1_bundle),
        .push_col    (s1_x_reg),
        .reserve     (s1_push),
        .item_room   (q_room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .col         (col),
        .row         (row),
        .run_last    (run_last)
    );

    a_pend_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !(s1_valid_reg && (s1_x_reg != '0)))
        else $error("deferred line write collides with left write");

    a_row_start_after_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s1_valid_reg && s1_last_col_reg) |-> (col_count_reg == '0))
        else $error("item after last column is not column 0");

    a_left_only_past_col0: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_has_left_reg) |-> (s1_x_reg != '0))
        else $error("left result requested in column 0");

endmodule

`default_nettype wire
